// ----- rtl/core/utf8_stream_decoder_unit_defines.svh -----
// Assertion macros shared by the decoder RTL.
// Every macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8SD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/u8sd_pkg.sv -----
`timescale 1ns / 1ps

package u8sd_pkg;

    // Queue between the front end and the back end
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // A queue entry holds up to four bytes, so its length needs three bits
    localparam int LEN_W = 3;
    localparam int CP_W  = 21;

    typedef logic [3:0][7:0] u8sd_bytes_t;

    // One unit of work for the back end: bytes to decode, lead byte in slot 0
    typedef struct packed {
        u8sd_bytes_t      bytes;
        logic [LEN_W-1:0] len;
    } u8sd_entry_t;

    // Number of continuation bytes that a lead byte asks for
    function automatic logic [1:0] cont_count(input logic [7:0] c);
        logic [1:0] k;
        case (c) inside
            8'b0???????: k = 2'd0;
            8'b110?????: k = 2'd1;
            8'b1110????: k = 2'd2;
            8'b11110???: k = 2'd3;
            default:     k = 2'd0;
        endcase
        return k;
    endfunction

    // Assemble a code point from a lead byte and k continuation bytes.
    // A lead with no continuation (including invalid leads) passes through.
    function automatic logic [CP_W-1:0] decode_seq(input u8sd_bytes_t b,
                                                   input logic [1:0] k);
        logic [CP_W-1:0] v;
        case (k)
            2'd0:    v = {13'd0, b[0]};
            2'd1:    v = {10'd0, b[0][4:0], b[1][5:0]};
            2'd2:    v = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            2'd3:    v = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/u8sd_front.sv -----
`timescale 1ns / 1ps

`include "utf8_stream_decoder_unit_defines.svh"

module u8sd_front
    import u8sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        q_push,
    output u8sd_entry_t q_data
);

    logic [1:0] held_cnt_reg;
    logic [1:0] held_cnt_next;
    logic [1:0] needed_reg;
    logic [1:0] needed_next;
    logic [7:0] held_byte_reg [0:2];
    logic [1:0] lead_k;
    logic       store_byte;

    assign lead_k = cont_count(data_byte);

    // Entry: held bytes followed by the new byte
    always_comb
    begin
        q_data.bytes[0] = (held_cnt_reg > 2'd0) ? held_byte_reg[0] : data_byte;
        q_data.bytes[1] = (held_cnt_reg > 2'd1) ? held_byte_reg[1] : data_byte;
        q_data.bytes[2] = (held_cnt_reg > 2'd2) ? held_byte_reg[2] : data_byte;
        q_data.bytes[3] = data_byte;
        q_data.len      = {1'b0, held_cnt_reg} + LEN_W'(1);
    end

    // Classify the byte: hand work to the back end, or gather it
    always_comb
    begin
        q_push        = 1'b0;
        store_byte    = 1'b0;
        held_cnt_next = held_cnt_reg;
        needed_next   = needed_reg;
        if (accept)
        begin
            if (buffer_end)
            begin
                q_push        = 1'b1;
                held_cnt_next = 2'd0;
                needed_next   = 2'd0;
            end
            else if (held_cnt_reg == 2'd0)
            begin
                if (lead_k == 2'd0)
                begin
                    q_push = 1'b1;
                end
                else
                begin
                    store_byte    = 1'b1;
                    held_cnt_next = 2'd1;
                    needed_next   = lead_k;
                end
            end
            else if (needed_reg == 2'd1)
            begin
                q_push        = 1'b1;
                held_cnt_next = 2'd0;
                needed_next   = 2'd0;
            end
            else
            begin
                store_byte    = 1'b1;
                held_cnt_next = held_cnt_reg + 2'd1;
                needed_next   = needed_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            needed_reg   <= 2'd0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            needed_reg   <= needed_next;
        end
    end

    // Held bytes of the open sequence
    always_ff @(posedge clk)
    begin
        if (store_byte && (held_cnt_reg != 2'd3))
        begin
            held_byte_reg[held_cnt_reg] <= data_byte;
        end
    end

    `U8SD_ASSERT_SAME(a_open_seq_needs_bytes, held_cnt_reg != 2'd0, needed_reg != 2'd0, "open sequence with nothing missing")

endmodule

// ----- rtl/core/u8sd_fifo.sv -----
`timescale 1ns / 1ps

`include "utf8_stream_decoder_unit_defines.svh"

module u8sd_fifo
    import u8sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  u8sd_entry_t wr_data,
    output logic        full,
    input  logic        rd_en,
    output u8sd_entry_t rd_data,
    output logic        empty
);

    u8sd_entry_t       mem_reg [0:Q_DEPTH-1];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == Q_CW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `U8SD_ASSERT_SAME(a_q_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with pointers apart")

endmodule

// ----- rtl/core/u8sd_back.sv -----
`timescale 1ns / 1ps

`include "utf8_stream_decoder_unit_defines.svh"

module u8sd_back
    import u8sd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  u8sd_entry_t     q_data,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] code_point,
    output logic            end_of_text,
    output logic            last_of_run
);

    u8sd_bytes_t      work_bytes_reg;
    u8sd_bytes_t      work_bytes_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CP_W-1:0]  out_cp_reg;
    logic             out_eot_reg;
    logic             out_last_reg;

    logic [1:0]       k;
    logic [LEN_W-1:0] need;
    logic             fits;
    logic [LEN_W-1:0] adv;
    logic [LEN_W-1:0] rem_after;
    logic [CP_W-1:0]  step_cp;
    logic             take;
    logic             step;
    logic             load;
    u8sd_bytes_t      shifted;

    // Decode the sequence that starts at the front of the work bytes
    assign k         = cont_count(work_bytes_reg[0]);
    assign need      = {1'b0, k} + LEN_W'(1);
    assign fits      = (need <= rem_reg);
    assign adv       = fits ? need : LEN_W'(1);
    assign rem_after = rem_reg - adv;
    assign step_cp   = fits ? decode_seq(work_bytes_reg, k) : '0;

    // Output register free, or being emptied this cycle
    assign take  = !out_valid_reg || pop;
    assign step  = (rem_reg != '0) && take;
    assign load  = !q_empty && ((rem_reg == '0) || (step && (rem_after == '0)));
    assign q_pop = load;

    // Drop the consumed bytes
    always_comb
    begin
        case (adv)
            3'd1:    shifted = {8'd0, work_bytes_reg[3:1]};
            3'd2:    shifted = {16'd0, work_bytes_reg[3:2]};
            3'd3:    shifted = {24'd0, work_bytes_reg[3]};
            default: shifted = '0;
        endcase
    end

    always_comb
    begin
        work_bytes_next = work_bytes_reg;
        rem_next        = rem_reg;
        if (load)
        begin
            work_bytes_next = q_data.bytes;
            rem_next        = q_data.len;
        end
        else if (step)
        begin
            work_bytes_next = shifted;
            rem_next        = rem_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work bytes and result payload
    always_ff @(posedge clk)
    begin
        work_bytes_reg <= work_bytes_next;
        if (step)
        begin
            out_cp_reg   <= step_cp;
            out_eot_reg  <= !fits;
            out_last_reg <= (rem_after == '0);
        end
    end

    assign empty       = !out_valid_reg;
    assign code_point  = out_cp_reg;
    assign end_of_text = out_eot_reg;
    assign last_of_run = out_last_reg;

    `U8SD_ASSERT_NEXT(a_load_gives_work, load, rem_reg != '0, "loaded entry with no bytes")
    `U8SD_ASSERT_SAME(a_eot_zero_cp, out_valid_reg && out_eot_reg, out_cp_reg == '0, "end-of-text result with non-zero code point")

endmodule

// ----- rtl/core/utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps

// UTF-8 stream decoder. Bytes go in through a queue-style port (push/full), one
// per cycle for as long as full is low; decoded code points come out through a
// queue-style port (empty/pop), at most one per cycle. A byte that completes a
// sequence, or a plain byte, gives one result; the byte flagged as buffer end
// flushes any open sequence and can give up to three results (end-of-text plus
// re-decoded bytes), which the back-end sequencer emits in order as the output
// register frees. The front end classifies bytes and gathers sequences; a
// four-entry queue of decode jobs separates it from the back end, so full only
// rises when the result side stalls or a run of buffer ends outpaces the
// one-result-per-cycle output. Results pass the queue, the work-byte register
// and output register. last_of_run marks the final result caused by one byte.

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      data_byte,
    input  logic            buffer_end,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] code_point,
    output logic            end_of_text,
    output logic            last_of_run
);

    logic        accept;
    logic        q_push;
    u8sd_entry_t q_wr_data;
    logic        q_pop;
    u8sd_entry_t q_rd_data;
    logic        q_empty;

    // Input transfer
    assign accept = push && !full;

    u8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    u8sd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    u8sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .end_of_text (end_of_text),
        .last_of_run (last_of_run)
    );

endmodule
